@@ design/mjdf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mjdf_pkg
// shared types and constants of the multichannel jump debounce filter
// ----------------------------------------------------------------------------
package mjdf_pkg;

  localparam int unsigned CHAN_W     = 5;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CNT_W-1:0]    STABLE_COUNT_RST   = 4'd5;
  localparam logic [SAMPLE_W-1:0] JUMP_THRESHOLD_RST = 24'd7;
  localparam logic [CNT_W-1:0]    JUMP_CONFIRM_RST   = 4'd3;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STABLE_COUNT   = 2'd0,
    REG_JUMP_THRESHOLD = 2'd1,
    REG_JUMP_CONFIRM   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]    stable_count;
    logic [SAMPLE_W-1:0] jump_threshold;
    logic [CNT_W-1:0]    jump_confirm;
  } cfg_t;

  // one per-channel entry of the state memory
  typedef struct packed {
    logic [SAMPLE_W-1:0] held;
    logic [CNT_W-1:0]    cnt;
  } entry_t;

  typedef struct packed {
    entry_t entry;
    logic   pending;
  } upd_t;

endpackage : mjdf_pkg
`default_nettype wire

@@ design/mjdf_ifs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mjdf channel interfaces
// valid/ready channels for samples, results and configuration writes
// ----------------------------------------------------------------------------
interface mjdf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [mjdf_pkg::CHAN_W-1:0]   chan;
  logic [mjdf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output chan, output sample, input ready);
  modport sink   (input valid, input chan, input sample, output ready);
endinterface : mjdf_sample_if

interface mjdf_result_if;
  logic                          valid;
  logic                          ready;
  logic [mjdf_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface : mjdf_result_if

interface mjdf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mjdf_pkg::CFG_IDX_W-1:0]  index;
  logic [mjdf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : mjdf_cfg_if
`default_nettype wire

@@ design/multichannel_jump_debounce_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_jump_debounce_filter_unit
// per-channel debounce filter with shared jump confirmation
// ----------------------------------------------------------------------------
// Takes one sample transfer per clock while the result side keeps up and
// returns one result transfer per sample, in order: the addressed
// channel's held value after the update. Sustained rate is one item per
// cycle when results are not held off, set by the registered read of the
// state ram. A sample's ram read is registered in stage 1 at the transfer
// edge; its update lands in the output register when stage 1 moves on and
// waits there for its result transfer. A result left waiting
// holds the sample side off once stage 1 is also full. Held value and count
// of each channel live in one ram of CHANNELS entries; a flip-flop valid
// bit per entry makes never-written entries read as zero, so there is no
// clearing pass after reset. The jump-pending flag is a single register
// shared by all channels. A sample whose channel is not below CHANNELS
// leaves all state alone and returns zero. Configuration writes are taken
// at any time (cfg ready is tied high) but should only be made while idle.
// ----------------------------------------------------------------------------
module multichannel_jump_debounce_filter_unit #(
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mjdf_sample_if.sink  samples,
  mjdf_result_if.source results,
  mjdf_cfg_if.sink     cfg
);

  localparam int unsigned AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ENTRY_W = $bits(mjdf_pkg::entry_t);

  // configuration
  mjdf_pkg::cfg_t regs;

  mjdf_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // stage 1: item whose ram read is in flight / returned
  logic                          s1_valid;
  logic [AW-1:0]                 s1_addr;
  logic                          s1_inr;
  logic [mjdf_pkg::SAMPLE_W-1:0] s1_sample;

  // output register
  logic                          out_valid;
  logic [mjdf_pkg::SAMPLE_W-1:0] out_data;

  // last write, for forwarding over the read-first ram
  logic                          fwd_valid;
  logic [AW-1:0]                 fwd_addr;
  mjdf_pkg::entry_t              fwd_data;

  logic [CHANNELS-1:0]           entry_valid;
  logic                          jump_pending;

  logic                          in_xfer;
  logic                          s1_adv;
  logic                          in_range;
  logic [AW-1:0]                 in_addr;
  logic                          ram_we;
  logic [ENTRY_W-1:0]            ram_rdata;
  mjdf_pkg::entry_t              cur;
  mjdf_pkg::upd_t                upd;

  // stage 1 moves on whenever the output register is free or being drained
  assign s1_adv        = s1_valid && (!out_valid || results.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign in_xfer       = samples.valid && samples.ready;
  assign in_range      = 32'(samples.chan) < CHANNELS;
  assign in_addr       = AW'(samples.chan);
  assign ram_we        = s1_adv && s1_inr;

  mjdf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (upd.entry),
    .re    (in_xfer),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // entry seen by the update: latest write wins, unwritten entries are zero
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur = fwd_data;
    end else if (entry_valid[s1_addr]) begin
      cur = mjdf_pkg::entry_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  mjdf_update u_upd (
    .regs    (regs),
    .cur     (cur),
    .pending (jump_pending),
    .sample  (s1_sample),
    .upd     (upd)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      fwd_valid    <= 1'b0;
      entry_valid  <= '0;
      jump_pending <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (ram_we) begin
        fwd_valid            <= 1'b1;
        entry_valid[s1_addr] <= 1'b1;
        jump_pending         <= upd.pending;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_addr   <= in_addr;
      s1_inr    <= in_range;
      s1_sample <= samples.sample;
    end
    if (s1_adv) begin
      out_data <= s1_inr ? upd.entry.held : '0;
    end
    if (ram_we) begin
      fwd_addr <= s1_addr;
      fwd_data <= upd.entry;
    end
  end

  assign results.valid    = out_valid;
  assign results.filtered = out_data;

  // out-of-range channels return zero
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !s1_inr) |=> (results.valid && results.filtered == '0))
    else $error("out-of-range channel gave a nonzero result");

  // a stalled stage 1 keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_addr) && $stable(s1_sample)))
    else $error("stage 1 item lost while stalled");

  // a written entry is marked valid and forwarded
  a_write_marks: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> (entry_valid[fwd_addr] && fwd_valid))
    else $error("written entry not marked valid");

endmodule : multichannel_jump_debounce_filter_unit
`default_nettype wire

@@ design/mjdf_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mjdf_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module mjdf_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read-first: a same-address write is not seen here
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : mjdf_ram
`default_nettype wire

@@ design/mjdf_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mjdf_cfg_regs
// configuration registers, written over the cfg channel
// ----------------------------------------------------------------------------
module mjdf_cfg_regs (
  input  wire logic  clk,
  input  wire logic  rst,
  mjdf_cfg_if.sink   cfg,
  output mjdf_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stable_count   <= mjdf_pkg::STABLE_COUNT_RST;
      regs.jump_threshold <= mjdf_pkg::JUMP_THRESHOLD_RST;
      regs.jump_confirm   <= mjdf_pkg::JUMP_CONFIRM_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mjdf_pkg::REG_STABLE_COUNT: begin
          regs.stable_count <= cfg.data[mjdf_pkg::CNT_W-1:0];
        end
        mjdf_pkg::REG_JUMP_THRESHOLD: begin
          regs.jump_threshold <= cfg.data[mjdf_pkg::SAMPLE_W-1:0];
        end
        mjdf_pkg::REG_JUMP_CONFIRM: begin
          regs.jump_confirm <= cfg.data[mjdf_pkg::CNT_W-1:0];
        end
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

endmodule : mjdf_cfg_regs
`default_nettype wire

@@ design/mjdf_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mjdf_update
// debounce and jump-confirm rule applied to one channel entry
// ----------------------------------------------------------------------------
module mjdf_update (
  input  wire mjdf_pkg::cfg_t                regs,
  input  wire mjdf_pkg::entry_t              cur,
  input  wire logic                          pending,
  input  wire logic [mjdf_pkg::SAMPLE_W-1:0] sample,
  output mjdf_pkg::upd_t                     upd
);

  logic [mjdf_pkg::SAMPLE_W-1:0] diff;
  logic                          is_jump;
  logic [mjdf_pkg::CNT_W-1:0]    cnt_inc;
  logic [mjdf_pkg::CNT_W-1:0]    stable_lim;

  always_comb begin
    diff       = (sample >= cur.held) ? (sample - cur.held) : (cur.held - sample);
    is_jump    = diff > regs.jump_threshold;
    cnt_inc    = cur.cnt + mjdf_pkg::CNT_W'(1);
    // a limit of zero wraps to fifteen
    stable_lim = regs.stable_count - mjdf_pkg::CNT_W'(1);

    upd.entry   = cur;
    upd.pending = pending;

    if (!pending) begin
      if (sample == cur.held) begin
        upd.entry.cnt = '0;
      end else if (cur.cnt == stable_lim) begin
        if (is_jump) begin
          upd.pending = 1'b1;
        end else begin
          upd.entry.held = sample;
        end
        upd.entry.cnt = '0;
      end else begin
        upd.entry.cnt = cnt_inc;
      end
    end else begin
      if (is_jump) begin
        upd.entry.cnt = cnt_inc;
        if (cnt_inc >= regs.jump_confirm) begin
          upd.entry.held = sample;
          upd.entry.cnt  = '0;
          upd.pending    = 1'b0;
        end
      end else begin
        upd.entry.cnt = '0;
        upd.pending   = 1'b0;
      end
    end
  end

endmodule : mjdf_update
`default_nettype wire

@@ dv/mjdf_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mjdf_check_pkg
// mirror of the debounce filter state and the queue of expected held values
// ----------------------------------------------------------------------------
package mjdf_check_pkg;
  import mjdf_pkg::*;

  localparam int unsigned NUM_CHANNELS = 32;

  class channel_filter_state;
    logic [SAMPLE_W-1:0] held [NUM_CHANNELS];
    logic [CNT_W-1:0]    cnt  [NUM_CHANNELS];
    logic                jump_pending;
    logic [CNT_W-1:0]    stable_count;
    logic [SAMPLE_W-1:0] jump_threshold;
    logic [CNT_W-1:0]    jump_confirm;
    logic [SAMPLE_W-1:0] filtered_due [$];
    int unsigned         mismatches;

    function new();
      foreach (held[i]) begin
        held[i] = '0;
        cnt[i]  = '0;
      end
      jump_pending   = 1'b0;
      stable_count   = STABLE_COUNT_RST;
      jump_threshold = JUMP_THRESHOLD_RST;
      jump_confirm   = JUMP_CONFIRM_RST;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STABLE_COUNT:   stable_count   = data[CNT_W-1:0];
        REG_JUMP_THRESHOLD: jump_threshold = data[SAMPLE_W-1:0];
        REG_JUMP_CONFIRM:   jump_confirm   = data[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit is_jump(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] h);
      logic [SAMPLE_W-1:0] gap;
      gap = (s >= h) ? s - h : h - s;
      return gap > jump_threshold;
    endfunction

    // updates the addressed channel and queues its held value
    function void take_sample(logic [CHAN_W-1:0] ch, logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] h;
      logic [CNT_W-1:0]    c;
      logic [CNT_W-1:0]    run_end;
      if (ch >= NUM_CHANNELS) begin
        filtered_due.push_back('0);
        return;
      end
      h       = held[ch];
      c       = cnt[ch];
      run_end = stable_count - 4'd1;
      if (!jump_pending) begin
        if (s == h) begin
          c = '0;
        end else if (c == run_end) begin
          if (is_jump(s, h)) jump_pending = 1'b1;
          else h = s;
          c = '0;
        end else begin
          c = c + 4'd1;
        end
      end else if (is_jump(s, h)) begin
        c = c + 4'd1;
        if (c >= jump_confirm) begin
          h            = s;
          c            = '0;
          jump_pending = 1'b0;
        end
      end else begin
        c            = '0;
        jump_pending = 1'b0;
      end
      held[ch] = h;
      cnt[ch]  = c;
      filtered_due.push_back(h);
    endfunction

    function void check_filtered(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (filtered_due.size() == 0) begin
        $error("filtered: no result expected, actual %0h", got);
        mismatches++;
        return;
      end
      want = filtered_due.pop_front();
      if (got !== want) begin
        $error("filtered: expected %0h, actual %0h", want, got);
        mismatches++;
      end
    endfunction
  endclass

endpackage : mjdf_check_pkg

@@ dv/tb_multichannel_jump_debounce_filter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multichannel_jump_debounce_filter_unit
// self-checking bench for the multichannel jump debounce filter
// ----------------------------------------------------------------------------
// Drives sample transfers on chosen channels, mirrors the per-channel held
// value, difference count and shared jump flag, and compares every result
// transfer with the mirrored held value. A short directed run is followed by
// phases under different register settings, each made of runs that settle a
// channel, raise and confirm jumps, cancel them from another channel, or
// just poke random values. Both sides idle in random bursts in phases that turn idling on, never in the last.
// ----------------------------------------------------------------------------
module tb_multichannel_jump_debounce_filter_unit;
  import mjdf_pkg::*;
  import mjdf_check_pkg::*;

  localparam int unsigned STALL_LIMIT  = 500;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned COUNT_MAX    = (1 << CNT_W) - 1;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = '1;
  localparam logic [CHAN_W-1:0]    CHAN_MAX   = '1;
  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

  logic clk;
  logic rst;

  mjdf_sample_if samples ();
  mjdf_result_if results ();
  mjdf_cfg_if    cfg ();

  multichannel_jump_debounce_filter_unit #(
    .CHANNELS (NUM_CHANNELS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  channel_filter_state tracker = new();

  // one idle burst starts with odds 1 in gap_odds per item or cycle, 0 = none
  int unsigned gap_odds     = 0;
  int unsigned items_sent   = 0;
  int unsigned stuck_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: ready drops in random bursts while idling is on
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gap_odds != 0 && hold == 0 && $urandom_range(0, gap_odds - 1) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold != 0) begin
        results.ready <= 1'b0;
        hold--;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  // result check and watchdog; values are the ones settled before the edge
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (results.valid && results.ready) tracker.check_filtered(results.filtered);
      if ((samples.valid && samples.ready) || (results.valid && results.ready) ||
          (cfg.valid && cfg.ready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      // nothing moved for far longer than any burst or drain allows
      if (stuck_cycles == STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // one sample transfer; valid stays high afterwards so items can run
  // back to back, a gap lowers it first
  task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    samples.valid  <= 1'b1;
    samples.chan   <= ch;
    samples.sample <= s;
    do @(posedge clk); while (!samples.ready);
    tracker.take_sample(ch, s);
    items_sent++;
  endtask

  // sender holds off until every queued result has come back
  task automatic drain();
    samples.valid <= 1'b0;
    while (tracker.filtered_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_transfer(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    tracker.set_reg(idx, data);
  endtask

  // 4-bit registers get random junk in the unused upper data bits
  task automatic apply_setting(input logic [CNT_W-1:0] st, input logic [SAMPLE_W-1:0] thr,
                               input logic [CNT_W-1:0] conf, input bit poke_spare);
    cfg_transfer(REG_STABLE_COUNT, CFG_DATA_W'({$urandom, st}));
    cfg_transfer(REG_JUMP_THRESHOLD, thr);
    cfg_transfer(REG_JUMP_CONFIRM, CFG_DATA_W'({$urandom, conf}));
    if (poke_spare) cfg_transfer(REG_SPARE, CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
  endtask

  // a sample within the threshold (equal to the held value when it is zero), often right at its edge
  function automatic logic [SAMPLE_W-1:0] near_of(input logic [SAMPLE_W-1:0] h);
    int unsigned off;
    off = (tracker.jump_threshold > 4096) ? 4096 : tracker.jump_threshold;
    if (off != 0 && $urandom_range(0, 3) != 0) off = $urandom_range(1, off);
    if (h >= off && (h + off > SAMPLE_MAX || $urandom_range(0, 1) == 0)) begin
      return SAMPLE_W'(h - off);
    end
    return SAMPLE_W'(h + off);
  endfunction

  // a sample beyond the threshold, often just one step past it; random when neither side has room
  function automatic logic [SAMPLE_W-1:0] far_of(input logic [SAMPLE_W-1:0] h);
    int unsigned thr;
    int unsigned bound;
    bit          can_lo;
    bit          can_hi;
    thr    = tracker.jump_threshold;
    can_lo = h > thr;
    can_hi = h + thr < SAMPLE_MAX;
    if (!can_lo && !can_hi) return SAMPLE_W'($urandom);
    if (can_hi && (!can_lo || $urandom_range(0, 1) == 0)) begin
      bound = h + thr + 1;
      if ($urandom_range(0, 3) == 0) return SAMPLE_W'(bound);
      return SAMPLE_W'($urandom_range(bound, SAMPLE_MAX));
    end
    bound = h - thr - 1;
    if ($urandom_range(0, 3) == 0) return SAMPLE_W'(bound);
    return SAMPLE_W'($urandom_range(0, bound));
  endfunction

  // one burst of related samples with random content
  task automatic run_scenario();
    int unsigned       kind;
    int unsigned       run_len;
    int unsigned       reps;
    int unsigned       i;
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    kind    = $urandom_range(0, 9);
    a       = CHAN_W'($urandom);
    b       = CHAN_W'($urandom);
    // differing samples that take a fresh count up to the decision
    run_len = ((tracker.stable_count - 1) & COUNT_MAX) + 1;
    case (kind)
      0, 1: begin
        send_sample(a, SAMPLE_W'($urandom));
      end
      2, 3, 4: begin
        // small moves, sometimes stopping one short of replacement
        reps = run_len - 1 + $urandom_range(0, 3);
        for (i = 0; i < reps; i++) send_sample(a, near_of(tracker.held[a]));
      end
      5, 6, 7: begin
        // raise a jump and confirm it, with the odd sample on another channel
        for (i = 0; i < run_len; i++) send_sample(a, far_of(tracker.held[a]));
        reps = tracker.jump_confirm + $urandom_range(0, 1);
        for (i = 0; i < reps; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            send_sample(b, $urandom_range(0, 1) ? far_of(tracker.held[b])
                                                : near_of(tracker.held[b]));
          end else begin
            send_sample(a, far_of(tracker.held[a]));
          end
        end
      end
      8: begin
        // same as held value, clears the count
        send_sample(a, tracker.held[a]);
      end
      default: begin
        // shared flag: jump raised on one channel, resolved by another
        for (i = 0; i < run_len; i++) send_sample(a, far_of(tracker.held[a]));
        send_sample(b, $urandom_range(0, 1) ? far_of(tracker.held[b])
                                            : near_of(tracker.held[b]));
      end
    endcase
  endtask

  // with a stable count of zero a count can sit at its maximum; a jump sample
  // on that channel while another channel's jump is open wraps it to zero
  task automatic count_wrap_case();
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    int unsigned       i;
    a = CHAN_W'($urandom);
    b = a ^ CHAN_W'(1);
    send_sample(a, tracker.held[a]);
    send_sample(b, tracker.held[b]);
    for (i = 0; i < COUNT_MAX; i++) send_sample(b, near_of(tracker.held[b]));
    for (i = 0; i <= COUNT_MAX; i++) send_sample(a, far_of(tracker.held[a]));
    send_sample(b, far_of(tracker.held[b]));
    send_sample(b, far_of(tracker.held[b]));
  endtask

  // directed items under the reset settings (stable 5, threshold 7, confirm 3)
  task automatic directed_run();
    int unsigned i;
    send_sample('0, '0);                                  // equal to cleared value
    for (i = 0; i < 5; i++) send_sample(CHAN_MAX, 24'd4); // small move, replaced on 5th
    for (i = 0; i < 8; i++) send_sample(CHAN_MAX, SAMPLE_MAX); // jump flagged, confirmed
    for (i = 0; i < 5; i++) send_sample('0, SAMPLE_MAX);  // jump flagged on channel 0
    send_sample(CHAN_MAX, SAMPLE_MAX - 24'd5);            // cancelled from another channel
    send_sample(CHAN_MAX, SAMPLE_MAX - 24'd7);            // difference exactly at threshold
    send_sample('0, 24'd8);                               // one past threshold
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned target;
    rst            <= 1'b1;
    samples.valid  <= 1'b0;
    samples.chan   <= '0;
    samples.sample <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= '0;
    cfg.data       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    gap_odds = 6;
    directed_run();

    for (p = 0; p < PHASES; p++) begin
      // registers change only with nothing in flight
      drain();
      case (p)
        0: apply_setting(4'd1, '0, 4'd1, 1'b0);
        1: apply_setting(4'd15, SAMPLE_MAX, 4'd15, 1'b0);
        2: apply_setting(4'd0, 24'd50, 4'd4, 1'b0);       // limit wraps to 15
        3: apply_setting(4'd3, 24'd1000, 4'd0, 1'b1);     // any pending jump taken at once
        default: apply_setting(CNT_W'($urandom),
                               $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 64))
                                                    : SAMPLE_W'($urandom),
                               CNT_W'($urandom), $urandom_range(0, 1));
      endcase
      if (p == PHASES - 1) begin
        gap_odds = 0;  // final stretch at full rate
      end else begin
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 3;
          2: gap_odds = 8;
          default: gap_odds = 25;
        endcase
      end
      if (p == 2) count_wrap_case();
      target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < target) run_scenario();
    end

    drain();
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule : tb_multichannel_jump_debounce_filter_unit
